// ===== design/ialu_pkg.sv =====
// Shared types, codes and helpers for the integer ALU with exceptions.
`default_nettype none
package ialu_pkg;

    localparam int TAG_BITS  = 6;
    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 2 * DATA_W;
    localparam int DIV_STEPS = DATA_W;

    // Opcodes
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADDI = 5'd1,
        OP_SUB  = 5'd2,
        OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,
        OP_REM  = 5'd5,
        OP_SLT  = 5'd6,
        OP_SLTI = 5'd7,
        OP_AND  = 5'd8,
        OP_ANDI = 5'd9,
        OP_OR   = 5'd10,
        OP_ORI  = 5'd11,
        OP_XOR  = 5'd12,
        OP_XORI = 5'd13,
        OP_BEQ  = 5'd14,
        OP_BNE  = 5'd15,
        OP_BLT  = 5'd16,
        OP_BLE  = 5'd17,
        OP_J    = 5'd18
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIGH = 2'd0;
    localparam logic [1:0] CFG_LOW  = 2'd1;

    // What the divider row does with a word
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_DIV  = 2'd1,
        K_REM  = 2'd2
    } t_kind;

    // Word leaving the decode/execute stage
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                checked;
        logic [WIDE_W-1:0]   wide;
        t_kind               kind;
        logic                neg;
        logic [DATA_W-1:0]   dq;
        logic [DATA_W-1:0]   dvs;
        logic                fault;
    } t_front;

    // Word moving along the divider cells; dq holds the result for plain ops
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        t_kind               kind;
        logic                neg;
        logic [DATA_W-1:0]   dq;
        logic [DATA_W-1:0]   rem;
        logic [DATA_W-1:0]   dvs;
        logic                fault;
    } t_cell;

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
        abs32 = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage
`default_nettype wire

// ===== design/ialu_front.sv =====
// Decode and execute stage: simple ops, 64-bit add/sub/mul, divider setup.
`default_nettype none
module ialu_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [4:0]                    i_op,
    input  wire logic signed [31:0]            i_src_a,
    input  wire logic signed [31:0]            i_src_b,
    input  wire logic signed [31:0]            i_immediate,
    input  wire logic [ialu_pkg::TAG_BITS-1:0] i_tag_in,
    output logic                               o_valid,
    input  wire logic                          i_dn_ready,
    output ialu_pkg::t_front                   o_word
);

    logic             r_valid;
    ialu_pkg::t_front r_word;
    ialu_pkg::t_front n_word;
    logic signed [63:0] w_a;
    logic signed [63:0] w_b;
    logic signed [63:0] w_i;

    assign o_ready = !r_valid || i_dn_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // sign-extend operands to the wide width
    assign w_a = {{32{i_src_a[31]}}, i_src_a};
    assign w_b = {{32{i_src_b[31]}}, i_src_b};
    assign w_i = {{32{i_immediate[31]}}, i_immediate};

    // opcode decode and execute
    always_comb begin
        n_word         = '0;
        n_word.tag     = i_tag_in;
        n_word.kind    = ialu_pkg::K_NONE;
        n_word.dvs     = ialu_pkg::abs32(i_src_b);
        unique case (ialu_pkg::t_op'(i_op))
            ialu_pkg::OP_ADD: begin
                n_word.checked = 1'b1;
                n_word.wide    = w_a + w_b;
            end
            ialu_pkg::OP_ADDI: begin
                n_word.checked = 1'b1;
                n_word.wide    = w_a + w_i;
            end
            ialu_pkg::OP_SUB: begin
                n_word.checked = 1'b1;
                n_word.wide    = w_a - w_b;
            end
            ialu_pkg::OP_MUL: begin
                n_word.checked = 1'b1;
                n_word.wide    = i_src_a * i_src_b;
            end
            ialu_pkg::OP_DIV: begin
                if (i_src_b == '0) begin
                    n_word.fault = 1'b1;
                end else begin
                    n_word.kind = ialu_pkg::K_DIV;
                    n_word.neg  = i_src_a[31] ^ i_src_b[31];
                    n_word.dq   = ialu_pkg::abs32(i_src_a);
                end
            end
            ialu_pkg::OP_REM: begin
                if (i_src_b == '0) begin
                    n_word.fault = 1'b1;
                end else begin
                    n_word.kind = ialu_pkg::K_REM;
                    n_word.neg  = i_src_a[31];
                    n_word.dq   = ialu_pkg::abs32(i_src_a);
                end
            end
            ialu_pkg::OP_SLT, ialu_pkg::OP_BLT: n_word.dq = {31'b0, i_src_a < i_src_b};
            ialu_pkg::OP_SLTI: n_word.dq = {31'b0, i_src_a < i_immediate};
            ialu_pkg::OP_AND:  n_word.dq = i_src_a & i_src_b;
            ialu_pkg::OP_ANDI: n_word.dq = i_src_a & i_immediate;
            ialu_pkg::OP_OR:   n_word.dq = i_src_a | i_src_b;
            ialu_pkg::OP_ORI:  n_word.dq = i_src_a | i_immediate;
            ialu_pkg::OP_XOR:  n_word.dq = i_src_a ^ i_src_b;
            ialu_pkg::OP_XORI: n_word.dq = i_src_a ^ i_immediate;
            ialu_pkg::OP_BEQ:  n_word.dq = {31'b0, i_src_a == i_src_b};
            ialu_pkg::OP_BNE:  n_word.dq = {31'b0, i_src_a != i_src_b};
            ialu_pkg::OP_BLE:  n_word.dq = {31'b0, i_src_a <= i_src_b};
            ialu_pkg::OP_J:    n_word.dq = 32'd1;
            default:           n_word.dq = '0;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// ===== design/ialu_check.sv =====
// Limit check stage: compares the wide result with the configured limits.
`default_nettype none
module ialu_check (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ialu_pkg::t_front i_word,
    input  wire logic [31:0]      i_lim_high,
    input  wire logic [31:0]      i_lim_low,
    output logic                  o_valid,
    input  wire logic             i_dn_ready,
    output ialu_pkg::t_cell       o_word
);

    logic            r_valid;
    ialu_pkg::t_cell r_word;
    ialu_pkg::t_cell n_word;
    logic            w_over;
    logic            w_under;

    assign o_ready = !r_valid || i_dn_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    assign w_over  = $signed(i_word.wide) > $signed({{32{i_lim_high[31]}}, i_lim_high});
    assign w_under = $signed(i_word.wide) < $signed({{32{i_lim_low[31]}}, i_lim_low});

    // merge limit fault, keep low half of the wide result
    always_comb begin
        n_word       = '0;
        n_word.tag   = i_word.tag;
        n_word.kind  = i_word.kind;
        n_word.neg   = i_word.neg;
        n_word.dvs   = i_word.dvs;
        n_word.dq    = i_word.checked ? i_word.wide[31:0] : i_word.dq;
        n_word.fault = i_word.fault | (i_word.checked & (w_over | w_under));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// ===== design/ialu_div_cell.sv =====
// One divider cell: one restoring quotient bit per word, then a register.
`default_nettype none
module ialu_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ialu_pkg::t_cell i_word,
    output logic                 o_valid,
    input  wire logic            i_dn_ready,
    output ialu_pkg::t_cell      o_word
);

    logic            r_valid;
    ialu_pkg::t_cell r_word;
    ialu_pkg::t_cell n_word;
    logic [32:0]     w_shift;
    logic [32:0]     w_diff;

    assign o_ready = !r_valid || i_dn_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    assign w_shift = {i_word.rem, i_word.dq[31]};
    assign w_diff  = w_shift - {1'b0, i_word.dvs};

    // trial subtract; plain-op words pass untouched
    always_comb begin
        n_word = i_word;
        if (i_word.kind != ialu_pkg::K_NONE) begin
            n_word.rem = w_diff[32] ? w_shift[31:0] : w_diff[31:0];
            n_word.dq  = {i_word.dq[30:0], ~w_diff[32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// ===== design/integer_alu_with_exceptions_unit.sv =====
// Top level: execute stage, limit check, divider cell row and output register.
// Path: execute, limit check, one quotient bit in each of the 32 divider cells,
//   then the output register.
// Throughput: one word per cycle unless the output stalls; every stage is a
//   registered cell with its own valid, so bubbles close up while the output waits.
// Reset: synchronous active-low; clears all valid bits and loads the limits with
//   the full signed 32-bit range.
`default_nettype none
module integer_alu_with_exceptions_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [4:0]                    i_op,
    input  wire logic signed [31:0]            i_src_a,
    input  wire logic signed [31:0]            i_src_b,
    input  wire logic signed [31:0]            i_immediate,
    input  wire logic [ialu_pkg::TAG_BITS-1:0] i_tag_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ialu_pkg::TAG_BITS-1:0]      o_tag_out,
    output logic signed [31:0]                 o_value,
    output logic                               o_fault,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    localparam int N = ialu_pkg::DIV_STEPS;

    logic [31:0]      r_lim_high;
    logic [31:0]      r_lim_low;
    logic             w_f_valid;
    logic             w_f_ready;
    ialu_pkg::t_front w_f_word;
    ialu_pkg::t_cell  w_cell [N+1];
    logic             w_vld  [N+1];
    logic             w_rdy  [N+1];

    logic                          r_out_valid;
    logic [ialu_pkg::TAG_BITS-1:0] r_tag;
    logic [31:0]                   r_value;
    logic                          r_fault;
    logic [31:0]                   n_value;
    ialu_pkg::t_cell               w_last;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_high <= 32'h7FFF_FFFF;
            r_lim_low  <= 32'h8000_0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ialu_pkg::CFG_HIGH: r_lim_high <= i_cfg_data;
                ialu_pkg::CFG_LOW:  r_lim_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ialu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_src_a     (i_src_a),
        .i_src_b     (i_src_b),
        .i_immediate (i_immediate),
        .i_tag_in    (i_tag_in),
        .o_valid     (w_f_valid),
        .i_dn_ready  (w_f_ready),
        .o_word      (w_f_word)
    );

    ialu_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_f_valid),
        .o_ready    (w_f_ready),
        .i_word     (w_f_word),
        .i_lim_high (r_lim_high),
        .i_lim_low  (r_lim_low),
        .o_valid    (w_vld[0]),
        .i_dn_ready (w_rdy[0]),
        .o_word     (w_cell[0])
    );

    // divider cell row
    for (genvar k = 0; k < N; k++) begin : g_cell
        ialu_div_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_vld[k]),
            .o_ready    (w_rdy[k]),
            .i_word     (w_cell[k]),
            .o_valid    (w_vld[k+1]),
            .i_dn_ready (w_rdy[k+1]),
            .o_word     (w_cell[k+1])
        );
    end

    // sign fixup of quotient or remainder
    assign w_last = w_cell[N];
    always_comb begin
        case (w_last.kind)
            ialu_pkg::K_DIV: n_value = w_last.neg ? (~w_last.dq + 1'b1) : w_last.dq;
            ialu_pkg::K_REM: n_value = w_last.neg ? (~w_last.rem + 1'b1) : w_last.rem;
            default:         n_value = w_last.dq;
        endcase
    end

    // output register
    assign w_rdy[N] = !r_out_valid || i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[N]) begin
            r_out_valid <= w_vld[N];
        end
        if (w_rdy[N]) begin
            r_tag   <= w_last.tag;
            r_value <= n_value;
            r_fault <= w_last.fault;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_tag_out = r_tag;
    assign o_value   = r_value;
    assign o_fault   = r_fault;

    // reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a divide never enters the row with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[0] && (w_cell[0].kind != ialu_pkg::K_NONE) |-> (w_cell[0].dvs != '0))
        else $error("zero divisor in divider row");

    // final remainder magnitude below divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[N] && (w_last.kind != ialu_pkg::K_NONE) |-> (w_last.rem < w_last.dvs))
        else $error("remainder not below divisor");

endmodule
`default_nettype wire
